// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values, message-schedule helpers and the
// item type passed from the front end to the compression engine.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BlockBytes   = 64;
	localparam int LenOffset    = 56;
	localparam int Rounds       = 64;
	localparam int QueueDepth   = 4;
	localparam logic [7:0] PadByte = 8'h80;

	// one byte-level operation for the engine
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       message_end;
	} sha_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMPRESS,
		ST_PAD,
		ST_LEN,
		ST_EMIT
	} sha_state_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and emits each message digest as four 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis_*: tdata carries data_byte, tuser carries
//   byte_valid, tlast carries message_end. An item may append a byte, end
//   the message, both (byte first) or neither.
//   Results leave on m_axis_*: tdata is the digest word (most significant
//   word first), tuser is word_index, tlast marks the fourth word.
// Timing:
//   Items go into a four-entry queue; the engine takes one queued item per
//   cycle while idle. Every 64th byte starts a compression (one round per
//   cycle), during which the engine takes no items. Message end adds a
//   padding step and a compression, plus a length-load step and a second
//   compression when the length spills into another block, and then four
//   output words.
// Reset:
//   arst_n clears the queue, the byte count and the bit count and loads the
//   initial hash values.
// Stall:
//   While m_axis_tready is low the current digest word holds and the engine
//   waits; the queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
	import sha_pkg::*;
#(
	parameter int QDepth = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] byte_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [63:0] digest_word
	output logic [1:0]  m_axis_tuser,   // [1:0] word_index
	output logic        m_axis_tlast
);

	sha_item_t in_item, q_item;
	logic      q_valid, q_ready;

	assign in_item = '{data_byte: s_axis_tdata, byte_valid: s_axis_tuser,
		message_end: s_axis_tlast};

	// front: accept and hold items
	sha_front #(.Depth(QDepth)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	// back: buffer, compress, pad and emit
	sha_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_item      (q_item),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.digest_word (m_axis_tdata),
		.word_index  (m_axis_tuser),
		.last_word   (m_axis_tlast)
	);

endmodule

// ===== rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// SHA-256 front end
// Takes input items and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module sha_front
	import sha_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sha_item_t in_item,
	output logic      q_valid,
	input  logic      q_ready,
	output sha_item_t q_item
);

	localparam int AW = $clog2(Depth);

	sha_item_t        mem_q [Depth];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push, pop;

	assign in_ready = (count_q != (AW+1)'(Depth));
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			// advance pointers, wrap at the depth
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

endmodule

// ===== rtl/sha_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine
// Buffers bytes, pads, runs one round per cycle and emits the digest.
// ----------------------------------------------------------------------------
module sha_engine
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  sha_item_t   q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	sha_state_t  state_q, state_d;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];      // sliding message schedule window
	logic [6:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  round_q;
	logic [1:0]  widx_q;
	logic        end_q;         // message end pending after this block
	logic        need_len_q;    // length block still to compress after this one
	logic        final_q;       // padding under way, digest follows the last block

	// byte write into the window at the fill position (window = block bytes)
	logic [31:0] w_wr [16];
	logic [7:0]  wr_byte;
	logic [5:0]  wr_pos;
	logic        wr_en;

	logic [31:0] s0, s1, w_new, t1, t2;
	logic [63:0] bits_end;      // message length including the buffered bytes

	assign bits_end = bits_q + {54'd0, fill_q, 3'd0};

	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(round_q) + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.byte_valid && fill_q == 7'd63) begin
						state_d = ST_COMPRESS;
					end else if (q_item.message_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMPRESS: begin
				if (round_q == 6'd63) begin
					if (need_len_q) begin
						state_d = ST_LEN;
					end else if (final_q) begin
						state_d = ST_EMIT;
					end else if (end_q) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				state_d = ST_COMPRESS;
			end
			ST_LEN: begin
				state_d = ST_COMPRESS;
			end
			ST_EMIT: begin
				if (out_ready && widx_q == 2'd3) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_ready     = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_EMIT);
		digest_word = {h_q[{widx_q, 1'b0}], h_q[{widx_q, 1'b1}]};
		word_index  = widx_q;
		last_word   = (widx_q == 2'd3);
		wr_en   = (state_q == ST_IDLE) && q_valid && q_item.byte_valid;
		wr_byte = q_item.data_byte;
		wr_pos  = fill_q[5:0];
		for (int i = 0; i < 16; i++) begin
			w_wr[i] = w_q[i];
			if (wr_en && wr_pos[5:2] == 4'(i)) begin
				w_wr[i][8*(3-wr_pos[1:0]) +: 8] = wr_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				for (int i = 0; i < 16; i++) w_q[i] <= w_wr[i];
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			ST_PAD: begin
				// 0x80 then zero fill; length word if it fits
				for (int i = 0; i < 16; i++) begin
					if (7'(4*i) >= fill_q + 7'd1) begin
						w_q[i] <= '0;
					end else if (7'(4*i+4) > fill_q) begin
						for (int b = 0; b < 4; b++) begin
							if (7'(4*i+b) == fill_q) begin
								w_q[i][8*(3-b) +: 8] <= PadByte;
							end else if (7'(4*i+b) > fill_q) begin
								w_q[i][8*(3-b) +: 8] <= 8'h00;
							end
						end
					end
				end
				if (fill_q < 7'(LenOffset)) begin
					w_q[14] <= bits_end[63:32];
					w_q[15] <= bits_end[31:0];
				end
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			ST_LEN: begin
				for (int i = 0; i < 14; i++) w_q[i] <= '0;
				w_q[14] <= bits_q[63:32];
				w_q[15] <= bits_q[31:0];
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			ST_COMPRESS: begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				v_q[0] <= t1 + t2;
				v_q[1] <= v_q[0];
				v_q[2] <= v_q[1];
				v_q[3] <= v_q[2];
				v_q[4] <= v_q[3] + t1;
				v_q[5] <= v_q[4];
				v_q[6] <= v_q[5];
				v_q[7] <= v_q[6];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
			fill_q     <= '0;
			bits_q     <= '0;
			round_q    <= '0;
			widx_q     <= '0;
			end_q      <= 1'b0;
			need_len_q <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					round_q <= '0;
					if (q_valid) begin
						end_q <= q_item.message_end;
						if (q_item.byte_valid) begin
							if (fill_q == 7'd63) begin
								fill_q <= '0;
								bits_q <= bits_q + 64'd512;
							end else begin
								fill_q <= fill_q + 7'd1;
							end
						end
					end
				end
				ST_PAD: begin
					bits_q     <= bits_end;
					need_len_q <= (fill_q >= 7'(LenOffset));
					end_q      <= 1'b0;
					final_q    <= 1'b1;
				end
				ST_LEN: begin
					need_len_q <= 1'b0;
				end
				ST_COMPRESS: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						// fold the round result into the hash
						h_q[0] <= h_q[0] + t1 + t2;
						h_q[1] <= h_q[1] + v_q[0];
						h_q[2] <= h_q[2] + v_q[1];
						h_q[3] <= h_q[3] + v_q[2];
						h_q[4] <= h_q[4] + v_q[3] + t1;
						h_q[5] <= h_q[5] + v_q[4];
						h_q[6] <= h_q[6] + v_q[5];
						h_q[7] <= h_q[7] + v_q[6];
						if (state_d == ST_EMIT) begin
							widx_q <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						widx_q <= widx_q + 2'd1;
						if (widx_q == 2'd3) begin
							for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
							fill_q  <= '0;
							bits_q  <= '0;
							end_q   <= 1'b0;
							final_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/sha_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the top-level ports for output ordering and stall behavior.
// ----------------------------------------------------------------------------
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// last flag marks word three only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
		else $error("tlast does not match word index");

	// a taken non-final word is followed by the next index
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		(m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 2'd1))
		else $error("digest words out of order");

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled output changed");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
